FILE: rtl/plx_pkg.sv
// ----------------------------------------------------------------------------
// plx_pkg
// Shared types, token kinds and character codes for the punctuation lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package plx_pkg;

	// one source item
	typedef struct packed {
		logic [7:0] char_byte;
		logic       byte_valid;
		logic       end_of_source;
	} src_t;

	// one emitted token
	typedef struct packed {
		logic [4:0]  token_kind;
		logic [31:0] start_pos;
		logic [31:0] token_length;
		logic [31:0] line_number;
		logic        last_of_run;
	} tok_t;

	// all tokens caused by one source item
	typedef struct packed {
		logic [1:0]       count;
		tok_t [2:0]       toks;
	} tok_group_t;

	// scanner mode
	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_HELD    = 2'd1,
		MODE_COMMENT = 2'd2,
		MODE_STRING  = 2'd3
	} mode_t;

	// held operator codes
	localparam logic [2:0] HK_BANG    = 3'd0;
	localparam logic [2:0] HK_EQUAL   = 3'd1;
	localparam logic [2:0] HK_LESS    = 3'd2;
	localparam logic [2:0] HK_GREATER = 3'd3;
	localparam logic [2:0] HK_SLASH   = 3'd4;

	// token kinds
	localparam logic [4:0] KIND_LPAREN     = 5'd0;
	localparam logic [4:0] KIND_RPAREN     = 5'd1;
	localparam logic [4:0] KIND_LBRACE     = 5'd2;
	localparam logic [4:0] KIND_RBRACE     = 5'd3;
	localparam logic [4:0] KIND_COMMA      = 5'd4;
	localparam logic [4:0] KIND_DOT        = 5'd5;
	localparam logic [4:0] KIND_MINUS      = 5'd6;
	localparam logic [4:0] KIND_PLUS       = 5'd7;
	localparam logic [4:0] KIND_SEMICOLON  = 5'd8;
	localparam logic [4:0] KIND_STAR       = 5'd9;
	localparam logic [4:0] KIND_SLASH      = 5'd10;
	localparam logic [4:0] KIND_BANG       = 5'd11;
	localparam logic [4:0] KIND_BANG_EQUAL = 5'd12;
	localparam logic [4:0] KIND_STRING     = 5'd19;
	localparam logic [4:0] KIND_END        = 5'd20;
	localparam logic [4:0] KIND_UNEXPECTED = 5'd21;
	localparam logic [4:0] KIND_UNFINISHED = 5'd22;

	// character codes
	localparam logic [7:0] CH_LPAREN    = 8'h28;
	localparam logic [7:0] CH_RPAREN    = 8'h29;
	localparam logic [7:0] CH_LBRACE    = 8'h7B;
	localparam logic [7:0] CH_RBRACE    = 8'h7D;
	localparam logic [7:0] CH_COMMA     = 8'h2C;
	localparam logic [7:0] CH_DOT       = 8'h2E;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_PLUS      = 8'h2B;
	localparam logic [7:0] CH_SEMICOLON = 8'h3B;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_BANG      = 8'h21;
	localparam logic [7:0] CH_EQUAL     = 8'h3D;
	localparam logic [7:0] CH_LESS      = 8'h3C;
	localparam logic [7:0] CH_GREATER   = 8'h3E;
	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_CR        = 8'h0D;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// kind of a held operator, alone or with a trailing equal sign
	function automatic logic [4:0] held_kind(input logic [2:0] hk, input logic two);
		logic [4:0] base;
		base = KIND_BANG + 5'({hk[1:0], 1'b0});
		if (hk >= HK_SLASH) begin
			return KIND_SLASH;
		end
		return two ? base + 5'd1 : base;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/plx_scan.sv
// ----------------------------------------------------------------------------
// plx_scan
// Input register, scanner state and the single-pass token logic.
// ----------------------------------------------------------------------------
`default_nettype none

module plx_scan
	import plx_pkg::*;
#(
	parameter int POS_BITS  = 32,
	parameter int LINE_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_ready,
	input  wire src_t       src_data,
	input  wire logic       buf_free,
	output logic            buf_push,
	output tok_group_t      group
);

	localparam int PW  = POS_BITS + 1;
	localparam int PCW = (PW > 33) ? PW : 33;
	localparam int LCW = (LINE_BITS > 33) ? LINE_BITS : 33;

	// input stage
	logic valid_s1;
	src_t item_s1;

	// scanner state
	mode_t                mode_q, mode_d;
	logic [2:0]           hk_q, hk_d;
	logic [POS_BITS-1:0]  hs_q, hs_d;
	logic [POS_BITS-1:0]  ss_q, ss_d;
	logic [POS_BITS-1:0]  pos_q, pos_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic                 fin_q, fin_d;

	logic       advance;
	logic       do_norm;
	logic [1:0] n;
	tok_t [2:0] t;
	logic [7:0] c;

	// clamp a position or length to the 32-bit result field
	function automatic logic [31:0] sat_pos(input logic [PW-1:0] v);
		logic [PCW-1:0] x;
		x = PCW'(v);
		return (x > PCW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	function automatic logic [31:0] sat_line(input logic [LINE_BITS-1:0] v);
		logic [LCW-1:0] x;
		x = LCW'(v);
		return (x > LCW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : x[31:0];
	endfunction

	// distance between two offsets, never below zero
	function automatic logic [PW-1:0] span(input logic [POS_BITS-1:0] from,
			input logic [POS_BITS-1:0] to);
		return (to > from) ? {1'b0, to - from} : '0;
	endfunction

	function automatic tok_t make_tok(input logic [4:0] kind, input logic [31:0] start,
			input logic [31:0] len, input logic [31:0] line);
		tok_t r;
		r.token_kind   = kind;
		r.start_pos    = start;
		r.token_length = len;
		r.line_number  = line;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

	assign c = item_s1.char_byte;

	// scan one item: next state and up to three tokens
	always_comb begin
		mode_d  = mode_q;
		hk_d    = hk_q;
		hs_d    = hs_q;
		ss_d    = ss_q;
		pos_d   = pos_q;
		line_d  = line_q;
		fin_d   = fin_q;
		do_norm = 1'b0;
		n       = '0;
		t       = '0;
		if (valid_s1 && !fin_q) begin
			if (item_s1.byte_valid) begin
				case (mode_q)
					MODE_HELD: begin
						if (hk_q >= HK_SLASH && c == CH_SLASH) begin
							mode_d = MODE_COMMENT;
						end else if (hk_q < HK_SLASH && c == CH_EQUAL) begin
							t[n] = make_tok(held_kind(hk_q, 1'b1), sat_pos({1'b0, hs_q}),
								sat_pos(span(hs_q, pos_q) + PW'(1)), sat_line(line_d));
							n = n + 2'd1;
							mode_d = MODE_NORMAL;
						end else begin
							t[n] = make_tok(held_kind(hk_q, 1'b0), sat_pos({1'b0, hs_q}),
								32'd1, sat_line(line_d));
							n = n + 2'd1;
							mode_d  = MODE_NORMAL;
							do_norm = 1'b1;
						end
					end
					MODE_COMMENT: begin
						if (c == CH_NEWLINE) begin
							line_d = (&line_d) ? line_d : line_d + LINE_BITS'(1);
							mode_d = MODE_NORMAL;
						end
					end
					MODE_STRING: begin
						if (c == CH_QUOTE) begin
							t[n] = make_tok(KIND_STRING, sat_pos({1'b0, ss_q}),
								sat_pos(span(ss_q, pos_q) + PW'(1)), sat_line(line_d));
							n = n + 2'd1;
							mode_d = MODE_NORMAL;
						end else if (c == CH_NEWLINE) begin
							line_d = (&line_d) ? line_d : line_d + LINE_BITS'(1);
						end
					end
					default: begin
						do_norm = 1'b1;
					end
				endcase

				// plain scanning of the byte
				if (do_norm) begin
					case (c)
						CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA,
						CH_DOT, CH_MINUS, CH_PLUS, CH_SEMICOLON, CH_STAR: begin
							t[n] = make_tok(KIND_UNEXPECTED, sat_pos({1'b0, pos_q}), 32'd1,
								sat_line(line_d));
							case (c)
								CH_LPAREN:    t[n].token_kind = KIND_LPAREN;
								CH_RPAREN:    t[n].token_kind = KIND_RPAREN;
								CH_LBRACE:    t[n].token_kind = KIND_LBRACE;
								CH_RBRACE:    t[n].token_kind = KIND_RBRACE;
								CH_COMMA:     t[n].token_kind = KIND_COMMA;
								CH_DOT:       t[n].token_kind = KIND_DOT;
								CH_MINUS:     t[n].token_kind = KIND_MINUS;
								CH_PLUS:      t[n].token_kind = KIND_PLUS;
								CH_SEMICOLON: t[n].token_kind = KIND_SEMICOLON;
								default:      t[n].token_kind = KIND_STAR;
							endcase
							n = n + 2'd1;
						end
						CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER, CH_SLASH: begin
							case (c)
								CH_BANG:    hk_d = HK_BANG;
								CH_EQUAL:   hk_d = HK_EQUAL;
								CH_LESS:    hk_d = HK_LESS;
								CH_GREATER: hk_d = HK_GREATER;
								default:    hk_d = HK_SLASH;
							endcase
							hs_d   = pos_q;
							mode_d = MODE_HELD;
						end
						CH_SPACE, CH_TAB, CH_CR: begin
						end
						CH_NEWLINE: begin
							line_d = (&line_d) ? line_d : line_d + LINE_BITS'(1);
						end
						CH_QUOTE: begin
							ss_d   = pos_q;
							mode_d = MODE_STRING;
						end
						default: begin
							t[n] = make_tok(KIND_UNEXPECTED, sat_pos({1'b0, pos_q}), 32'd1,
								sat_line(line_d));
							n = n + 2'd1;
						end
					endcase
				end

				pos_d = (&pos_q) ? pos_q : pos_q + POS_BITS'(1);
			end

			// end of source: flush held operator or open string, then end token
			if (item_s1.end_of_source) begin
				if (mode_d == MODE_HELD) begin
					t[n] = make_tok(held_kind(hk_d, 1'b0), sat_pos({1'b0, hs_d}), 32'd1,
						sat_line(line_d));
					n = n + 2'd1;
				end else if (mode_d == MODE_STRING) begin
					t[n] = make_tok(KIND_UNFINISHED, sat_pos({1'b0, ss_d}),
						sat_pos(span(ss_d, pos_d)), sat_line(line_d));
					n = n + 2'd1;
				end
				mode_d = MODE_NORMAL;
				t[n] = make_tok(KIND_END, sat_pos({1'b0, pos_d}), 32'd0, sat_line(line_d));
				n = n + 2'd1;
				fin_d = 1'b1;
			end
		end

		// mark the final token of the run
		for (int i = 0; i < 3; i++) begin
			t[i].last_of_run = (n == 2'(i + 1));
		end
	end

	// handoff to the result buffer
	assign advance     = valid_s1 && ((n == 2'd0) || buf_free);
	assign buf_push    = advance && (n != 2'd0);
	assign src_ready   = !valid_s1 || advance;
	assign group.count = n;
	assign group.toks  = t;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_ready) begin
			valid_s1 <= src_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (src_ready) begin
			item_s1 <= src_data;
		end
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			hk_q   <= '0;
			hs_q   <= '0;
			ss_q   <= '0;
			pos_q  <= '0;
			line_q <= LINE_BITS'(1);
			fin_q  <= 1'b0;
		end else if (advance) begin
			mode_q <= mode_d;
			hk_q   <= hk_d;
			hs_q   <= hs_d;
			ss_q   <= ss_d;
			pos_q  <= pos_d;
			line_q <= line_d;
			fin_q  <= fin_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/plx_tokbuf.sv
// ----------------------------------------------------------------------------
// plx_tokbuf
// Result register holding the tokens of one item, handed out one per request.
// ----------------------------------------------------------------------------
`default_nettype none

module plx_tokbuf
	import plx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire tok_group_t group,
	output logic            free,
	output logic            tok_valid,
	input  wire logic       tok_ready,
	output tok_t            tok_data
);

	logic [1:0] cnt_q;
	tok_t [2:0] slot_q;
	logic       take;

	// output side
	assign tok_valid = (cnt_q != 2'd0);
	assign tok_data  = slot_q[0];
	assign take      = tok_valid && tok_ready;
	assign free      = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && tok_ready);

	// token count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= group.count;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// token slots, shifted down as each request goes out
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q <= group.toks;
		end else if (take) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/punctuation_lexer.sv
// Path: a source byte passes the input register, the scan logic and the result register to its first token.
// Throughput: one source byte per cycle while each byte yields at most one token and tok_ready holds;
// a byte that yields more tokens holds the result register until they are taken.
// Reset: asynchronous; line count starts at one, position and mode clear,
// no clearing pass, items are taken right after reset.
// ----------------------------------------------------------------------------
// punctuation_lexer
// Streaming scanner for punctuation, operators, comments and strings.
// ----------------------------------------------------------------------------
`default_nettype none

module punctuation_lexer
	import plx_pkg::*;
#(
	parameter int POS_BITS  = 32,
	parameter int LINE_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic src_valid,
	output logic      src_ready,
	input  wire src_t src_data,
	output logic      tok_valid,
	input  wire logic tok_ready,
	output tok_t      tok_data
);

	logic       buf_free;
	logic       buf_push;
	tok_group_t group;

	// scanner with input stage
	plx_scan #(
		.POS_BITS  (POS_BITS),
		.LINE_BITS (LINE_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.buf_free  (buf_free),
		.buf_push  (buf_push),
		.group     (group)
	);

	// result register
	plx_tokbuf u_tokbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (buf_push),
		.group     (group),
		.free      (buf_free),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

endmodule

`default_nettype wire
